// ----- design/bll_pkg.sv -----
package bll_pkg;

   // widths of the transaction fields
   localparam int FIELD_W = 12;
   localparam int CMD_W   = 2;

   // depth saturates here
   localparam logic [FIELD_W-1:0] DEPTH_MAX = {FIELD_W{1'b1}};

   typedef logic [FIELD_W-1:0] node_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD = 2'd0,
      CMD_LCA = 2'd1,
      CMD_ANC = 2'd2
   } cmd_type;

endpackage

// ----- design/bll_if.sv -----
// request channel: command and two node fields
interface bll_req_if;
   logic                          valid;
   logic                          ready;
   logic [bll_pkg::CMD_W-1:0]     cmd;
   logic [bll_pkg::FIELD_W-1:0]   node_a;
   logic [bll_pkg::FIELD_W-1:0]   node_b;

   modport source (output valid, output cmd, output node_a, output node_b, input ready);
   modport sink   (input valid, input cmd, input node_a, input node_b, output ready);
endinterface

// response channel: one answer node
interface bll_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bll_pkg::FIELD_W-1:0]   result_node;

   modport source (output valid, output result_node, input ready);
   modport sink   (input valid, input result_node, output ready);
endinterface

// ----- design/bll_mem.sv -----
// Single write port, two read ports, registered read data.
// A read of the address being written in the same cycle returns the new data.
// A read flagged as the sentinel node returns zero.
module bll_mem #(
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  we,
   input  logic [ADDR_W-1:0]     waddr,
   input  bll_pkg::node_type     wdata,
   input  logic [ADDR_W-1:0]     raddr_a,
   input  logic                  zero_a,
   input  logic [ADDR_W-1:0]     raddr_b,
   input  logic                  zero_b,
   output bll_pkg::node_type     rdata_a,
   output bll_pkg::node_type     rdata_b
);

   bll_pkg::node_type mem [DEPTH];

   bll_pkg::node_type q_a_ff, q_b_ff, wd_ff;
   logic              fwd_a_ff, fwd_b_ff, zero_a_ff, zero_b_ff;

   // write, read and capture bypass state
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      q_a_ff    <= mem[raddr_a];
      q_b_ff    <= mem[raddr_b];
      fwd_a_ff  <= we && (waddr == raddr_a);
      fwd_b_ff  <= we && (waddr == raddr_b);
      wd_ff     <= wdata;
      zero_a_ff <= zero_a;
      zero_b_ff <= zero_b;
   end

   // mask sentinel, forward fresh write
   assign rdata_a = zero_a_ff ? '0 : (fwd_a_ff ? wd_ff : q_a_ff);
   assign rdata_b = zero_b_ff ? '0 : (fwd_b_ff ? wd_ff : q_b_ff);

endmodule

// ----- design/binary_lifting_lca.sv -----
// Ancestor engine, one transaction at a time; ready is high only when idle.
// LCA: depth lookup, lift of the deeper node, then a climb of both only if the lifted nodes differ.
// Kth ancestor: depth lookup and lift, or straight to the result when the step count passes the root.
// Add: level 0 is written on acceptance, then one ancestor row entry per cycle through the table read port.
// A query holds ready low until its answer is loaded, so no new transaction is taken while one is in flight.
// Reset clears control only; table contents stay undefined, node 0 reads as zero by decode.
module binary_lifting_lca #(
   parameter int NODE_COUNT = 4096,
   parameter int LEVELS     = 12
) (
   input logic        clock,
   input logic        reset,
   bll_req_if.sink    req_chan,
   bll_rsp_if.source  rsp_chan
);

   localparam int NW        = $clog2(NODE_COUNT);
   localparam int LW        = $clog2(LEVELS);
   localparam int ANC_DEPTH = NODE_COUNT * LEVELS;
   localparam int AAW       = $clog2(ANC_DEPTH);

   typedef enum logic [3:0] {
      S_IDLE,
      S_ADD_FILL,
      S_DEPTH,
      S_LIFT,
      S_LIFT_END,
      S_CLIMB,
      S_CLIMB_LAST,
      S_FINAL,
      S_RESULT
   } state_type;

   function automatic logic [AAW-1:0] anc_addr(input bll_pkg::node_type node,
                                                input logic [LW-1:0] lvl);
      return AAW'(NW'(node)) * AAW'(LEVELS) + AAW'(lvl);
   endfunction

   state_type         state_ff, state_in;
   logic              is_lca_ff, is_lca_in;
   logic              pend_ff, pend_in;
   logic              par_zero_ff, par_zero_in;
   logic              out_valid_ff, out_valid_in;
   logic [LW-1:0]     lvl_ff, lvl_in;
   bll_pkg::node_type x_ff, x_in, y_ff, y_in, k_ff, k_in;
   bll_pkg::node_type add_node_ff, add_node_in;
   bll_pkg::node_type res_ff, res_in, out_node_ff, out_node_in;

   bll_pkg::node_type cur_x, cur_y, a_node, b_node;
   logic              a_ok;

   // table ports
   logic              anc_we;
   logic [AAW-1:0]    anc_waddr;
   bll_pkg::node_type anc_wdata, anc_qa, anc_qb;
   bll_pkg::node_type anc_node_a, anc_node_b;
   logic [LW-1:0]     anc_lvl_a, anc_lvl_b;
   logic              dep_we;
   logic [NW-1:0]     dep_waddr;
   bll_pkg::node_type dep_wdata, dep_qa, dep_qb;
   bll_pkg::node_type dep_node_a, dep_node_b;

   // map out-of-range nodes to the sentinel
   assign a_node = (32'(req_chan.node_a) < NODE_COUNT) ? req_chan.node_a : '0;
   assign b_node = (32'(req_chan.node_b) < NODE_COUNT) ? req_chan.node_b : '0;
   assign a_ok   = (req_chan.node_a != '0) && (32'(req_chan.node_a) < NODE_COUNT);

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.result_node = out_node_ff;

   // sequencer: next state, table accesses
   always_comb begin
      state_in     = state_ff;
      is_lca_in    = is_lca_ff;
      pend_in      = pend_ff;
      par_zero_in  = par_zero_ff;
      out_valid_in = out_valid_ff;
      lvl_in       = lvl_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      k_in         = k_ff;
      add_node_in  = add_node_ff;
      res_in       = res_ff;
      out_node_in  = out_node_ff;
      cur_x        = x_ff;
      cur_y        = y_ff;
      anc_we       = 1'b0;
      anc_waddr    = anc_addr(add_node_ff, lvl_ff);
      anc_wdata    = anc_qa;
      anc_node_a   = x_ff;
      anc_lvl_a    = lvl_ff;
      anc_node_b   = y_ff;
      anc_lvl_b    = lvl_ff;
      dep_we       = 1'b0;
      dep_waddr    = NW'(add_node_ff);
      dep_wdata    = par_zero_ff ? '0 :
                     ((dep_qa == bll_pkg::DEPTH_MAX) ? bll_pkg::DEPTH_MAX : dep_qa + 1'b1);
      dep_node_a   = x_ff;
      dep_node_b   = y_ff;

      // drop the response once taken
      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               case (bll_pkg::cmd_type'(req_chan.cmd))
                  bll_pkg::CMD_ADD: begin
                     if (a_ok) begin
                        anc_we      = 1'b1;
                        anc_waddr   = anc_addr(req_chan.node_a, '0);
                        anc_wdata   = b_node;
                        anc_node_a  = b_node;
                        anc_lvl_a   = '0;
                        dep_node_a  = b_node;
                        add_node_in = req_chan.node_a;
                        par_zero_in = (b_node == '0);
                        lvl_in      = LW'(1);
                        state_in    = S_ADD_FILL;
                     end
                  end
                  bll_pkg::CMD_LCA: begin
                     x_in       = a_node;
                     y_in       = b_node;
                     dep_node_a = a_node;
                     dep_node_b = b_node;
                     is_lca_in  = 1'b1;
                     state_in   = S_DEPTH;
                  end
                  bll_pkg::CMD_ANC: begin
                     x_in       = a_node;
                     k_in       = req_chan.node_b;
                     dep_node_a = a_node;
                     is_lca_in  = 1'b0;
                     state_in   = S_DEPTH;
                  end
                  default: ;
               endcase
            end
         end

         // write one row entry, fetch the next from the ancestor just found
         S_ADD_FILL: begin
            anc_we = 1'b1;
            if (lvl_ff == LW'(1)) begin
               dep_we = 1'b1;
            end
            if (lvl_ff == LW'(LEVELS - 1)) begin
               state_in = S_IDLE;
            end else begin
               anc_node_a = anc_qa;
               anc_lvl_a  = lvl_ff;
               lvl_in     = lvl_ff + 1'b1;
            end
         end

         // order the pair by depth, or reject a jump past the root
         S_DEPTH: begin
            lvl_in  = '0;
            pend_in = 1'b0;
            if (is_lca_ff) begin
               if (dep_qa < dep_qb) begin
                  x_in = y_ff;
                  y_in = x_ff;
                  k_in = dep_qb - dep_qa;
               end else begin
                  k_in = dep_qa - dep_qb;
               end
               state_in = S_LIFT;
            end else if (k_ff > dep_qa) begin
               res_in   = '0;
               state_in = S_RESULT;
            end else begin
               state_in = S_LIFT;
            end
         end

         // lift x by the set bits of the step count, lowest level first
         S_LIFT: begin
            cur_x      = pend_ff ? anc_qa : x_ff;
            anc_node_a = cur_x;
            pend_in    = k_ff[0];
            x_in       = cur_x;
            k_in       = k_ff >> 1;
            if (lvl_ff == LW'(LEVELS - 1)) begin
               state_in = S_LIFT_END;
            end else begin
               lvl_in = lvl_ff + 1'b1;
            end
         end

         S_LIFT_END: begin
            cur_x = pend_ff ? anc_qa : x_ff;
            x_in  = cur_x;
            if (!is_lca_ff || (cur_x == y_ff)) begin
               res_in   = cur_x;
               state_in = S_RESULT;
            end else begin
               lvl_in   = LW'(LEVELS - 1);
               pend_in  = 1'b0;
               state_in = S_CLIMB;
            end
         end

         // climb both nodes while their ancestors differ, highest level first
         S_CLIMB, S_CLIMB_LAST: begin
            if (pend_ff && (anc_qa != anc_qb)) begin
               cur_x = anc_qa;
               cur_y = anc_qb;
            end
            x_in       = cur_x;
            y_in       = cur_y;
            anc_node_a = cur_x;
            anc_node_b = cur_y;
            pend_in    = 1'b1;
            if (state_ff == S_CLIMB_LAST) begin
               anc_lvl_a = '0;
               state_in  = S_FINAL;
            end else if (lvl_ff == '0) begin
               state_in = S_CLIMB_LAST;
            end else begin
               lvl_in = lvl_ff - 1'b1;
            end
         end

         S_FINAL: begin
            res_in   = anc_qa;
            state_in = S_RESULT;
         end

         // hold the answer until the output register is free
         S_RESULT: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               out_valid_in = 1'b1;
               out_node_in  = res_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         pend_ff      <= pend_in;
      end
      is_lca_ff   <= is_lca_in;
      par_zero_ff <= par_zero_in;
      lvl_ff      <= lvl_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      k_ff        <= k_in;
      add_node_ff <= add_node_in;
      res_ff      <= res_in;
      out_node_ff <= out_node_in;
   end

   bll_mem #(
      .DEPTH (ANC_DEPTH)
   ) u_anc_mem (
      .clock   (clock),
      .we      (anc_we),
      .waddr   (anc_waddr),
      .wdata   (anc_wdata),
      .raddr_a (anc_addr(anc_node_a, anc_lvl_a)),
      .zero_a  (anc_node_a == '0),
      .raddr_b (anc_addr(anc_node_b, anc_lvl_b)),
      .zero_b  (anc_node_b == '0),
      .rdata_a (anc_qa),
      .rdata_b (anc_qb)
   );

   bll_mem #(
      .DEPTH (NODE_COUNT)
   ) u_depth_mem (
      .clock   (clock),
      .we      (dep_we),
      .waddr   (dep_waddr),
      .wdata   (dep_wdata),
      .raddr_a (NW'(dep_node_a)),
      .zero_a  (dep_node_a == '0),
      .raddr_b (NW'(dep_node_b)),
      .zero_b  (dep_node_b == '0),
      .rdata_a (dep_qa),
      .rdata_b (dep_qb)
   );

`ifndef SYNTH
   // no response can rise straight after a transaction is taken
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !$rose(rsp_chan.valid))
      else $error("response rose one cycle after request");

   // tables are written only while adding a node
   a_write_in_add: assert property (@(posedge clock) disable iff (reset)
      (anc_we || dep_we) |-> (state_ff == S_IDLE || state_ff == S_ADD_FILL))
      else $error("table write outside add");

   // row fill never revisits level zero
   a_fill_level: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADD_FILL) |-> (lvl_ff != '0))
      else $error("row fill at level zero");

   // a new answer is loaded only into a free output register
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESULT && out_valid_ff && !rsp_chan.ready) |=> (state_ff == S_RESULT))
      else $error("answer overwrote pending response");
`endif

endmodule

// ----- tb/lca_answer_checker.sv -----
`timescale 1ns / 1ps

module lca_answer_checker #(
   parameter int NODE_COUNT = 4096,
   parameter int LEVELS     = 12
) (
   input  logic clock,
   input  logic reset,
   bll_req_if   req_mon,
   bll_rsp_if   rsp_mon,
   output int   error_count,
   output int   answers_pending
);

   // shadow copy of the depth and jump tables
   bll_pkg::node_type node_depth [NODE_COUNT];
   bll_pkg::node_type jump_row   [NODE_COUNT][LEVELS];

   // answers owed by the block, oldest first
   bll_pkg::node_type expected_answers [$];

   initial begin
      for (int n = 0; n < NODE_COUNT; n++) begin
         node_depth[n] = '0;
         for (int i = 0; i < LEVELS; i++) jump_row[n][i] = '0;
      end
   end

   // map nodes outside the table onto the sentinel
   function automatic bll_pkg::node_type clamp_node(bll_pkg::node_type n);
      return (int'(n) < NODE_COUNT) ? n : bll_pkg::node_type'(0);
   endfunction

   // climb k levels, one power-of-two jump per set bit
   function automatic bll_pkg::node_type lift_node(bll_pkg::node_type x,
                                                   bll_pkg::node_type k);
      for (int i = 0; i < LEVELS && i < bll_pkg::FIELD_W; i++)
         if (k[i]) x = jump_row[x][i];
      return x;
   endfunction

   always @(posedge clock) begin : watch
      bll_pkg::node_type x, y, dx, dy, swap, got;
      if (reset) begin
         error_count     <= 0;
         answers_pending <= 0;
      end else begin
         // update the shadow tables and predict on each accepted request
         if (req_mon.valid && req_mon.ready) begin
            x = clamp_node(req_mon.node_a);
            y = clamp_node(req_mon.node_b);
            case (req_mon.cmd)
               bll_pkg::CMD_ADD: begin
                  // node 0 is never stored; depth saturates
                  if (x != '0) begin
                     if (y == '0)
                        dx = '0;
                     else if (node_depth[y] == bll_pkg::DEPTH_MAX)
                        dx = bll_pkg::DEPTH_MAX;
                     else
                        dx = node_depth[y] + 1'b1;
                     node_depth[x]  = dx;
                     jump_row[x][0] = y;
                     for (int i = 1; i < LEVELS; i++)
                        jump_row[x][i] = jump_row[jump_row[x][i-1]][i-1];
                  end
               end
               bll_pkg::CMD_LCA: begin
                  dx = node_depth[x];
                  dy = node_depth[y];
                  // deeper node goes first
                  if (dx < dy) begin
                     swap = x;  x  = y;  y  = swap;
                     swap = dx; dx = dy; dy = swap;
                  end
                  x = lift_node(x, dx - dy);
                  if (x != y) begin
                     for (int i = LEVELS - 1; i >= 0; i--)
                        if (jump_row[x][i] != jump_row[y][i]) begin
                           x = jump_row[x][i];
                           y = jump_row[y][i];
                        end
                     x = jump_row[x][0];
                  end
                  expected_answers.insert(expected_answers.size(), x);
               end
               bll_pkg::CMD_ANC: begin
                  // step count is taken raw, past the root gives the sentinel
                  if (req_mon.node_b > node_depth[x])
                     expected_answers.insert(expected_answers.size(),
                                             bll_pkg::node_type'(0));
                  else
                     expected_answers.insert(expected_answers.size(),
                                             lift_node(x, req_mon.node_b));
               end
               default: begin
               end
            endcase
         end

         // compare each accepted response with the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.result_node;
            if (expected_answers.size() == 0) begin
               $error("result_node: expected no transaction, got %0d", got);
               error_count <= error_count + 1;
            end else begin
               if (got !== expected_answers[0]) begin
                  $error("result_node: expected %0d, got %0d", expected_answers[0], got);
                  error_count <= error_count + 1;
               end
               void'(expected_answers.pop_front());
            end
         end

         answers_pending <= expected_answers.size();
      end
   end

endmodule

// ----- tb/tb_binary_lifting_lca.sv -----
`timescale 1ns / 1ps

module tb_binary_lifting_lca;

   localparam int NODES     = 4096;
   localparam int HOPS      = 12;
   localparam int ITEMS     = 550;
   localparam int CALM_FROM = 470;

   // command code the block does not decode
   localparam logic [bll_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

   logic clock;
   logic reset;
   int   error_count;
   int   answers_pending;
   int   useful;
   bit   calm;

   // nodes already added, in order of first addition
   bll_pkg::node_type grown [$];
   bit                in_tree [NODES];

   bll_req_if req_chan ();
   bll_rsp_if rsp_chan ();

   binary_lifting_lca #(
      .NODE_COUNT (NODES),
      .LEVELS     (HOPS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   lca_answer_checker #(
      .NODE_COUNT (NODES),
      .LEVELS     (HOPS)
   ) answer_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .error_count     (error_count),
      .answers_pending (answers_pending)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // stall the response side in bursts, none in the calm tail
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
      end
   end

   initial begin
      #4_000_000;
      $display("tb_binary_lifting_lca failed");
      $finish;
   end

   // random known node, optionally from the most recent additions
   function automatic bll_pkg::node_type pick_node(bit recent);
      int span;
      if (grown.size() == 0) return bll_pkg::node_type'(0);
      span = grown.size();
      if (recent && span > 10) span = 10;
      return grown[grown.size() - 1 - $urandom_range(0, span - 1)];
   endfunction

   // send one transaction, with an optional gap ahead of it
   task automatic issue(logic [bll_pkg::CMD_W-1:0] cmd, bll_pkg::node_type a,
                        bll_pkg::node_type b);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.cmd    <= cmd;
      req_chan.node_a <= a;
      req_chan.node_b <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      // track nodes so that queries only touch stored rows
      if (cmd == bll_pkg::CMD_ADD && a != '0 && !in_tree[a]) begin
         in_tree[a] = 1'b1;
         grown.insert(grown.size(), a);
      end
      if (cmd != CMD_SPARE && !(cmd == bll_pkg::CMD_ADD && a == '0)) useful++;
   endtask

   initial begin : stimulus
      bll_pkg::node_type a, b;
      int                roll;
      req_chan.valid  <= 1'b0;
      req_chan.cmd    <= bll_pkg::CMD_ADD;
      req_chan.node_a <= '0;
      req_chan.node_b <= '0;
      reset           <= 1'b1;
      useful = 0;
      calm   = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // sentinel queries on an empty forest
      issue(bll_pkg::CMD_LCA, 12'd0, 12'd0);
      issue(bll_pkg::CMD_ANC, 12'd0, 12'd4095);
      // adding node 0 is dropped
      issue(bll_pkg::CMD_ADD, 12'd0, 12'd0);
      // one tree with two branches under node 1
      issue(bll_pkg::CMD_ADD, 12'd4095, 12'd0);
      issue(bll_pkg::CMD_ADD, 12'd1, 12'd4095);
      issue(bll_pkg::CMD_ADD, 12'd2, 12'd1);
      issue(bll_pkg::CMD_ADD, 12'd3, 12'd2);
      issue(bll_pkg::CMD_ADD, 12'd2730, 12'd1);
      issue(bll_pkg::CMD_ADD, 12'd1365, 12'd2730);
      issue(bll_pkg::CMD_LCA, 12'd3, 12'd1365);
      issue(bll_pkg::CMD_LCA, 12'd3, 12'd3);
      issue(bll_pkg::CMD_LCA, 12'd2, 12'd3);
      issue(bll_pkg::CMD_LCA, 12'd3, 12'd0);
      // second root, so the forest has no common ancestor
      issue(bll_pkg::CMD_ADD, 12'd8, 12'd0);
      issue(bll_pkg::CMD_LCA, 12'd8, 12'd3);
      // zero steps, exactly to the root, and past it
      issue(bll_pkg::CMD_ANC, 12'd3, 12'd0);
      issue(bll_pkg::CMD_ANC, 12'd3, 12'd3);
      issue(bll_pkg::CMD_ANC, 12'd3, 12'd4);
      issue(bll_pkg::CMD_ANC, 12'd1365, 12'd4095);
      issue(CMD_SPARE, 12'd4095, 12'd4095);
      // re-add moves a node without touching its descendants
      issue(bll_pkg::CMD_ADD, 12'd2, 12'd8);
      issue(bll_pkg::CMD_LCA, 12'd3, 12'd8);
      issue(bll_pkg::CMD_ANC, 12'd3, 12'd2);
      // node as its own parent
      issue(bll_pkg::CMD_ADD, 12'd8, 12'd8);
      issue(bll_pkg::CMD_ANC, 12'd8, 12'd1);

      // mostly tree growth and queries, some noise and re-adds
      while (useful < ITEMS) begin
         calm = (useful >= CALM_FROM);
         roll = $urandom_range(0, 99);
         if (roll < 6) begin
            issue(CMD_SPARE, bll_pkg::node_type'($urandom_range(0, 4095)),
                  bll_pkg::node_type'($urandom_range(0, 4095)));
         end else if (roll < 9) begin
            issue(bll_pkg::CMD_ADD, bll_pkg::node_type'(0), pick_node(1'b0));
         end else if (roll < 13) begin
            b = ($urandom_range(0, 4) == 0) ? bll_pkg::node_type'(0) : pick_node(1'b0);
            issue(bll_pkg::CMD_ADD, pick_node(1'b0), b);
         end else if (roll < 45) begin
            // fresh node; lean towards extending the newest chain
            a = bll_pkg::node_type'($urandom_range(1, 4095));
            while (in_tree[a]) a = bll_pkg::node_type'($urandom_range(1, 4095));
            roll = $urandom_range(0, 9);
            if (roll == 0)
               b = '0;
            else if (roll < 6)
               b = grown[grown.size() - 1];
            else
               b = pick_node(1'b0);
            issue(bll_pkg::CMD_ADD, a, b);
         end else if (roll < 75) begin
            a    = pick_node(1'($urandom_range(0, 1)));
            roll = $urandom_range(0, 9);
            if (roll == 0)
               b = '0;
            else if (roll == 1)
               b = a;
            else if (roll < 6)
               b = pick_node(1'b1);
            else
               b = pick_node(1'b0);
            issue(bll_pkg::CMD_LCA, a, b);
         end else begin
            a = pick_node(1'($urandom_range(0, 1)));
            if ($urandom_range(0, 3) == 0)
               b = bll_pkg::node_type'($urandom_range(0, 4095));
            else
               b = bll_pkg::node_type'($urandom_range(0, 24));
            issue(bll_pkg::CMD_ANC, a, b);
         end
      end
      req_chan.valid <= 1'b0;

      // drain outstanding answers, then allow for a late stray one
      @(posedge clock);
      while (answers_pending != 0) @(posedge clock);
      repeat (2 * HOPS + 10) @(posedge clock);

      if (error_count == 0)
         $display("tb_binary_lifting_lca passed");
      else
         $display("tb_binary_lifting_lca failed");
      $finish;
   end

endmodule
